// ===== rtl/core/fcqc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcqc_pkg: shared types and constants of the face crop quality check
// Register map, field widths, verdict codes and the Laplacian kernel helper.
// ----------------------------------------------------------------------------
package fcqc_pkg;

    localparam int PIXEL_W      = 8;
    localparam int CFG_SIZE_W   = 9;
    localparam int BLUR_THR_W   = 20;
    localparam int LEVEL_THR_W  = 8;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;

    // register indexes, byte address = 4 * index
    typedef enum logic [2:0] {
        REG_FRAME_WIDTH      = 3'd0,
        REG_FRAME_HEIGHT     = 3'd1,
        REG_BLUR_THRESHOLD   = 3'd2,
        REG_DARK_THRESHOLD   = 3'd3,
        REG_BRIGHT_THRESHOLD = 3'd4
    } t_reg_idx;

    localparam logic [CFG_SIZE_W-1:0]  RST_FRAME_WIDTH      = 9'd256;
    localparam logic [CFG_SIZE_W-1:0]  RST_FRAME_HEIGHT     = 9'd256;
    localparam logic [BLUR_THR_W-1:0]  RST_BLUR_THRESHOLD   = 20'd65;
    localparam logic [LEVEL_THR_W-1:0] RST_DARK_THRESHOLD   = 8'd45;
    localparam logic [LEVEL_THR_W-1:0] RST_BRIGHT_THRESHOLD = 8'd235;

    // result word layout
    localparam int BRIGHTNESS_W = 24;
    localparam int EDGE_W       = 27;
    localparam int EDGE_SQ_W    = 36;
    localparam int OUT_DATA_W   = 96;
    localparam int OUT_PAD_W    = OUT_DATA_W - (1 + 2 + BRIGHTNESS_W + EDGE_W + EDGE_SQ_W);

    typedef enum logic [1:0] {
        VERDICT_GOOD   = 2'd0,
        VERDICT_BLURRY = 2'd1,
        VERDICT_DARK   = 2'd2,
        VERDICT_BRIGHT = 2'd3
    } t_verdict;

    typedef struct packed {
        logic     done;
        t_verdict verdict;
    } t_vrd_sts;

    typedef logic signed [10:0] t_lap;

    // up + down + left + right - 4 * center
    function automatic t_lap f_lap(
        input logic [PIXEL_W-1:0] ctr,
        input logic [PIXEL_W-1:0] up,
        input logic [PIXEL_W-1:0] dn,
        input logic [PIXEL_W-1:0] lf,
        input logic [PIXEL_W-1:0] rt
    );
        logic [9:0] sum4;
        sum4 = 10'(up) + 10'(dn) + 10'(lf) + 10'(rt);
        return $signed({1'b0, sum4}) - $signed({1'b0, ctr, 2'b00});
    endfunction

endpackage

// ===== rtl/core/face_crop_quality_check.sv =====
// ----------------------------------------------------------------------------
// face_crop_quality_check: blur and exposure check of a grayscale face crop
// Variance of the 3x3 Laplacian plus mean brightness limits, one verdict word
// per crop.
// ----------------------------------------------------------------------------
// Stream the crop in raster order, one pixel per slave word, at the width and
// height set over the APB port (values below 3 act as 3, values above
// MAX_WIDTH / MAX_HEIGHT act as the maximum). Pixels are taken at one per
// clock for the whole crop; the rate is set by the single line memory, which
// is read one column ahead of the pixel and written back at the pixel's
// column in the same cycle. After the crop's last pixel the slave side holds
// tready low while the Laplacian and square stages drain, while the verdict
// sequencer starts, and while one shared 32x32 multiplier builds the exact
// comparison products. The start waits, and tready stays low longer, while the
// previous verdict word is still unread. The verdict word then sits in the
// output register while the next crop streams in. Borders use reflect-101.
// Verdict priority is blurry, dark, bright, good; quality_ok is set only for
// good. Products are exact for crops of up to 65536 pixels and wrap modulo
// 2^64 beyond.
// ----------------------------------------------------------------------------
module face_crop_quality_check #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,   // [7:0] pixel
    // master stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [0] quality_ok, [2:1] verdict, [26:3] brightness_total,
    // [53:27] edge_total, [89:54] edge_square_total, [95:90] zero
    output logic [fcqc_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fcqc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [fcqc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fcqc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int     CW     = $clog2(MAX_WIDTH);
    localparam int     RW     = $clog2(MAX_HEIGHT);
    localparam int     XW     = (CW + 1 > fcqc_pkg::CFG_SIZE_W) ? CW + 1 : fcqc_pkg::CFG_SIZE_W;
    localparam int     XH     = (RW + 1 > fcqc_pkg::CFG_SIZE_W) ? RW + 1 : fcqc_pkg::CFG_SIZE_W;
    localparam longint NMAX   = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
    localparam int     AREA_W = $clog2(NMAX + 1);
    localparam int     PSW    = $clog2(255 * NMAX + 1);
    localparam int     ESW    = $clog2(1020 * NMAX + 1) + 1;
    localparam int     SQW    = $clog2(1040400 * NMAX + 1);

    typedef enum logic [2:0] {
        ST_STREAM = 3'b001,
        ST_DRAIN  = 3'b010,
        ST_CALC   = 3'b100
    } t_state;

    typedef struct packed {
        logic [7:0] older;
        logic [7:0] prev;
    } t_line_word;

    // configuration
    logic [fcqc_pkg::CFG_SIZE_W-1:0]  r_frame_width;
    logic [fcqc_pkg::CFG_SIZE_W-1:0]  r_frame_height;
    logic [fcqc_pkg::BLUR_THR_W-1:0]  r_blur_threshold;
    logic [fcqc_pkg::LEVEL_THR_W-1:0] r_dark_threshold;
    logic [fcqc_pkg::LEVEL_THR_W-1:0] r_bright_threshold;
    logic                             cfg_write;

    // frame control
    t_state              r_state;
    t_state              n_state;
    logic [CW-1:0]       r_col;
    logic [CW-1:0]       n_col;
    logic [RW-1:0]       r_row;
    logic [RW-1:0]       n_row;
    logic [XW-1:0]       w_ext;
    logic [XH-1:0]       h_ext;
    logic [CW-1:0]       w_last;
    logic [RW-1:0]       h_last;
    logic [CW:0]         w_size;
    logic [RW:0]         h_size;
    logic                last_col;
    logic                last_row;
    logic                s_accept;
    logic                m_accept;
    logic                calc_start;

    // line memory and window
    t_line_word          r_line_mem [MAX_WIDTH];
    t_line_word          r_line_rd;
    logic [7:0]          r_win [9];
    logic [7:0]          n_win [9];
    logic [7:0]          pixel;

    // Laplacian pipeline
    fcqc_pkg::t_lap      n_lap [4];
    logic [3:0]          lap_en;
    logic                r_s1_valid;
    fcqc_pkg::t_lap      r_s1_lap [4];
    logic                r_s2_valid;
    fcqc_pkg::t_lap      r_s2_lap [4];
    logic [19:0]         r_s2_sq [4];
    logic signed [21:0]  sq_full [4];
    logic signed [12:0]  lap_sum;
    logic [21:0]         sq_sum;

    // accumulators
    logic [PSW-1:0]         r_pix_acc;
    logic signed [ESW-1:0]  r_edge_acc;
    logic [SQW-1:0]         r_sq_acc;
    logic [63:0]            pix64;
    logic [63:0]            edge64;
    logic [63:0]            sq64;

    // result
    fcqc_pkg::t_vrd_sts                 vrd_sts;
    logic                               r_out_valid;
    logic [fcqc_pkg::OUT_DATA_W-1:0]    r_out_data;

    // ------------------------------------------------------------------
    // APB registers: pready is always high, write in the access phase
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width      <= fcqc_pkg::RST_FRAME_WIDTH;
            r_frame_height     <= fcqc_pkg::RST_FRAME_HEIGHT;
            r_blur_threshold   <= fcqc_pkg::RST_BLUR_THRESHOLD;
            r_dark_threshold   <= fcqc_pkg::RST_DARK_THRESHOLD;
            r_bright_threshold <= fcqc_pkg::RST_BRIGHT_THRESHOLD;
        end else if (cfg_write) begin
            case (paddr[4:2])
                fcqc_pkg::REG_FRAME_WIDTH:
                    r_frame_width <= pwdata[fcqc_pkg::CFG_SIZE_W-1:0];
                fcqc_pkg::REG_FRAME_HEIGHT:
                    r_frame_height <= pwdata[fcqc_pkg::CFG_SIZE_W-1:0];
                fcqc_pkg::REG_BLUR_THRESHOLD:
                    r_blur_threshold <= pwdata[fcqc_pkg::BLUR_THR_W-1:0];
                fcqc_pkg::REG_DARK_THRESHOLD:
                    r_dark_threshold <= pwdata[fcqc_pkg::LEVEL_THR_W-1:0];
                fcqc_pkg::REG_BRIGHT_THRESHOLD:
                    r_bright_threshold <= pwdata[fcqc_pkg::LEVEL_THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            fcqc_pkg::REG_FRAME_WIDTH:      prdata = 32'(r_frame_width);
            fcqc_pkg::REG_FRAME_HEIGHT:     prdata = 32'(r_frame_height);
            fcqc_pkg::REG_BLUR_THRESHOLD:   prdata = 32'(r_blur_threshold);
            fcqc_pkg::REG_DARK_THRESHOLD:   prdata = 32'(r_dark_threshold);
            fcqc_pkg::REG_BRIGHT_THRESHOLD: prdata = 32'(r_bright_threshold);
            default:                        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Frame size: clamp to [3, MAX] and keep the last column / row index
    // ------------------------------------------------------------------
    assign w_ext = XW'(r_frame_width);
    assign h_ext = XH'(r_frame_height);

    always_comb begin
        if (w_ext < XW'(3)) begin
            w_last = CW'(2);
        end else if (w_ext > XW'(MAX_WIDTH)) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(w_ext - XW'(1));
        end
        if (h_ext < XH'(3)) begin
            h_last = RW'(2);
        end else if (h_ext > XH'(MAX_HEIGHT)) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(h_ext - XH'(1));
        end
    end

    assign w_size = (CW + 1)'(w_last) + (CW + 1)'(1);
    assign h_size = (RW + 1)'(h_last) + (RW + 1)'(1);

    // a size shrunk under a running counter makes that column or row the last
    assign last_col = r_col >= w_last;
    assign last_row = r_row >= h_last;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign m_accept = o_m_tvalid && i_m_tready;
    assign pixel    = i_s_tdata;

    assign n_col = last_col ? '0 : r_col + CW'(1);
    always_comb begin
        n_row = r_row;
        if (last_col) begin
            n_row = last_row ? '0 : r_row + RW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Control: stream pixels, drain the pipe, run the verdict sequencer
    // ------------------------------------------------------------------
    assign o_s_tready = (r_state == ST_STREAM);
    assign calc_start = (r_state == ST_DRAIN) && !r_s1_valid && !r_s2_valid
                        && !r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_STREAM: begin
                if (s_accept && last_col && last_row) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (calc_start) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (vrd_sts.done) begin
                    n_state = ST_STREAM;
                end
            end
            default: n_state = ST_STREAM;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_STREAM;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            if (s_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line memory: one word per column holds the two rows above. Read the
    // next column ahead, write back the current one in the same cycle; the
    // two addresses never meet since a row has at least three columns.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_line_mem[r_col] <= '{older: r_line_rd.prev, prev: pixel};
            r_line_rd         <= r_line_mem[n_col];
        end
    end

    // shift the 3x3 window left, new column enters on the right
    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = r_line_rd.older;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = r_line_rd.prev;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = pixel;
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_win <= n_win;
        end
    end

    // Up to four centers finish per pixel: the one up-left of the pixel,
    // the one above it at the row end, the one left of it on the bottom row,
    // and the pixel itself at the crop's last position. Borders reflect.
    always_comb begin
        lap_en[0] = (r_row != '0) && (r_col != '0);
        lap_en[1] = (r_row != '0) && last_col;
        lap_en[2] = last_row && (r_col != '0);
        lap_en[3] = last_row && last_col;

        n_lap[0] = fcqc_pkg::f_lap(n_win[4],
                                   (r_row == RW'(1)) ? n_win[7] : n_win[1], n_win[7],
                                   (r_col == CW'(1)) ? n_win[5] : n_win[3], n_win[5]);
        n_lap[1] = fcqc_pkg::f_lap(n_win[5],
                                   (r_row == RW'(1)) ? n_win[8] : n_win[2], n_win[8],
                                   n_win[4], n_win[4]);
        n_lap[2] = fcqc_pkg::f_lap(n_win[7], n_win[4], n_win[4],
                                   (r_col == CW'(1)) ? n_win[8] : n_win[6], n_win[8]);
        n_lap[3] = fcqc_pkg::f_lap(n_win[8], n_win[5], n_win[5], n_win[7], n_win[7]);
    end

    // stage 1: gated Laplacian values; stage 2: squares; then accumulate
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sq_full[k] = 22'(r_s1_lap[k]) * 22'(r_s1_lap[k]);
        end
        lap_sum = 13'(r_s2_lap[0]) + 13'(r_s2_lap[1])
                + 13'(r_s2_lap[2]) + 13'(r_s2_lap[3]);
        sq_sum  = 22'(r_s2_sq[0]) + 22'(r_s2_sq[1])
                + 22'(r_s2_sq[2]) + 22'(r_s2_sq[3]);
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            for (int k = 0; k < 4; k++) begin
                r_s1_lap[k] <= lap_en[k] ? n_lap[k] : '0;
            end
        end
        if (r_s1_valid) begin
            for (int k = 0; k < 4; k++) begin
                r_s2_lap[k] <= r_s1_lap[k];
                r_s2_sq[k]  <= sq_full[k][19:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_pix_acc  <= '0;
            r_edge_acc <= '0;
            r_sq_acc   <= '0;
        end else begin
            r_s1_valid <= s_accept;
            r_s2_valid <= r_s1_valid;
            if (vrd_sts.done) begin
                // crop delivered: start the next one from zero
                r_pix_acc  <= '0;
                r_edge_acc <= '0;
                r_sq_acc   <= '0;
            end else begin
                if (s_accept) begin
                    r_pix_acc <= r_pix_acc + PSW'(pixel);
                end
                if (r_s2_valid) begin
                    r_edge_acc <= r_edge_acc + ESW'(lap_sum);
                    r_sq_acc   <= r_sq_acc + SQW'(sq_sum);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Verdict sequencer
    // ------------------------------------------------------------------
    fcqc_verdict #(
        .WIDTH_W    (CW + 1),
        .HEIGHT_W   (RW + 1),
        .AREA_W     (AREA_W),
        .PIX_SUM_W  (PSW),
        .EDGE_SUM_W (ESW),
        .SQ_SUM_W   (SQW)
    ) u_verdict (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (calc_start),
        .i_width            (w_size),
        .i_height           (h_size),
        .i_blur_threshold   (r_blur_threshold),
        .i_dark_threshold   (r_dark_threshold),
        .i_bright_threshold (r_bright_threshold),
        .i_pix_sum          (r_pix_acc),
        .i_edge_sum         (r_edge_acc),
        .i_sq_sum           (r_sq_acc),
        .o_sts              (vrd_sts)
    );

    // ------------------------------------------------------------------
    // Output register: hold the verdict word until the master side takes it
    // ------------------------------------------------------------------
    assign pix64  = 64'(r_pix_acc);
    assign edge64 = 64'(r_edge_acc);
    assign sq64   = 64'(r_sq_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (vrd_sts.done) begin
            r_out_valid <= 1'b1;
        end else if (m_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (vrd_sts.done) begin
            r_out_data <= {{fcqc_pkg::OUT_PAD_W{1'b0}},
                           sq64[fcqc_pkg::EDGE_SQ_W-1:0],
                           edge64[fcqc_pkg::EDGE_W-1:0],
                           pix64[fcqc_pkg::BRIGHTNESS_W-1:0],
                           vrd_sts.verdict,
                           (vrd_sts.verdict == fcqc_pkg::VERDICT_GOOD)};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== rtl/core/fcqc_verdict.sv =====
// ----------------------------------------------------------------------------
// fcqc_verdict: end-of-crop variance and brightness decision
// Runs the exact integer comparisons on one shared 32x32 multiplier; an even
// step issues each partial product, the odd step folds it, all modulo 2^64.
// ----------------------------------------------------------------------------
module fcqc_verdict #(
    parameter int WIDTH_W    = 9,
    parameter int HEIGHT_W   = 9,
    parameter int AREA_W     = 17,
    parameter int PIX_SUM_W  = 24,
    parameter int EDGE_SUM_W = 27,
    parameter int SQ_SUM_W   = 36
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [WIDTH_W-1:0]                    i_width,
    input  logic [HEIGHT_W-1:0]                   i_height,
    input  logic [fcqc_pkg::BLUR_THR_W-1:0]       i_blur_threshold,
    input  logic [fcqc_pkg::LEVEL_THR_W-1:0]      i_dark_threshold,
    input  logic [fcqc_pkg::LEVEL_THR_W-1:0]      i_bright_threshold,
    input  logic [PIX_SUM_W-1:0]                  i_pix_sum,
    input  logic signed [EDGE_SUM_W-1:0]          i_edge_sum,
    input  logic [SQ_SUM_W-1:0]                   i_sq_sum,
    output fcqc_pkg::t_vrd_sts                    o_sts
);

    localparam int TN_W  = fcqc_pkg::BLUR_THR_W + AREA_W;
    localparam int LVN_W = fcqc_pkg::LEVEL_THR_W + AREA_W;

    typedef enum logic [3:0] {
        OP_AREA    = 4'd0,
        OP_SQ_LO   = 4'd1,
        OP_SQ_HI   = 4'd2,
        OP_S_LO    = 4'd3,
        OP_S_CROSS = 4'd4,
        OP_TN      = 4'd5,
        OP_LIM_LO  = 4'd6,
        OP_LIM_HI  = 4'd7,
        OP_DARK    = 4'd8,
        OP_BRIGHT  = 4'd9,
        OP_DECIDE  = 4'd10
    } t_mul_op;

    logic                r_busy;
    logic [4:0]          r_step;
    logic [63:0]         r_prod;
    logic [AREA_W-1:0]   r_n;
    logic [63:0]         r_mag;
    logic [TN_W-1:0]     r_tn;
    logic [63:0]         r_spread;
    logic [63:0]         r_limit;
    logic [LVN_W-1:0]    r_dark_n;
    logic [LVN_W-1:0]    r_bright_n;

    t_mul_op             op;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_p;
    logic [63:0]         sq64;
    logic [63:0]         tn64;
    logic [63:0]         s64;
    logic [63:0]         sum64;
    fcqc_pkg::t_verdict  verdict;

    assign op    = t_mul_op'(r_step[4:1]);
    assign sq64  = 64'(i_sq_sum);
    assign tn64  = 64'(r_tn);
    assign s64   = 64'(i_edge_sum);
    assign sum64 = 64'(i_pix_sum);

    // operand select: even step issues the product, odd step folds it
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_AREA: begin
                mul_a = 32'(i_width);
                mul_b = 32'(i_height);
            end
            OP_SQ_LO: begin
                mul_a = 32'(r_n);
                mul_b = sq64[31:0];
            end
            OP_SQ_HI: begin
                mul_a = 32'(r_n);
                mul_b = sq64[63:32];
            end
            OP_S_LO: begin
                mul_a = r_mag[31:0];
                mul_b = r_mag[31:0];
            end
            OP_S_CROSS: begin
                mul_a = r_mag[63:32];
                mul_b = r_mag[31:0];
            end
            OP_TN: begin
                mul_a = 32'(i_blur_threshold);
                mul_b = 32'(r_n);
            end
            OP_LIM_LO: begin
                mul_a = 32'(r_n);
                mul_b = tn64[31:0];
            end
            OP_LIM_HI: begin
                mul_a = 32'(r_n);
                mul_b = tn64[63:32];
            end
            OP_DARK: begin
                mul_a = 32'(i_dark_threshold);
                mul_b = 32'(r_n);
            end
            OP_BRIGHT: begin
                mul_a = 32'(i_bright_threshold);
                mul_b = 32'(r_n);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            if (op == OP_DECIDE) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (i_start) begin
            r_mag <= s64[63] ? (64'd0 - s64) : s64;
        end
        if (r_busy && r_step[0]) begin
            case (op)
                OP_AREA:    r_n        <= AREA_W'(r_prod);
                OP_SQ_LO:   r_spread   <= r_prod;
                OP_SQ_HI:   r_spread   <= r_spread + {r_prod[31:0], 32'd0};
                OP_S_LO:    r_spread   <= r_spread - r_prod;
                // cross term of the square: 2 * hi * lo shifted by 32
                OP_S_CROSS: r_spread   <= r_spread - {r_prod[30:0], 33'd0};
                OP_TN:      r_tn       <= TN_W'(r_prod);
                OP_LIM_LO:  r_limit    <= r_prod;
                OP_LIM_HI:  r_limit    <= r_limit + {r_prod[31:0], 32'd0};
                OP_DARK:    r_dark_n   <= LVN_W'(r_prod);
                OP_BRIGHT:  r_bright_n <= LVN_W'(r_prod);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_spread < r_limit) begin
            verdict = fcqc_pkg::VERDICT_BLURRY;
        end else if (sum64 < 64'(r_dark_n)) begin
            verdict = fcqc_pkg::VERDICT_DARK;
        end else if (sum64 > 64'(r_bright_n)) begin
            verdict = fcqc_pkg::VERDICT_BRIGHT;
        end else begin
            verdict = fcqc_pkg::VERDICT_GOOD;
        end
    end

    assign o_sts.done    = r_busy && (op == OP_DECIDE);
    assign o_sts.verdict = verdict;

endmodule
